// ===== src/mm3_pkg.sv =====
package mm3_pkg;

   // Matrix size and derived counts.
   localparam int DIM   = 3;
   localparam int CELLS = DIM * DIM;

   // Element and result widths fixed by the stream fields.
   localparam int ELEM_W     = 16;
   localparam int MUL_W      = 2 * ELEM_W;
   localparam int PROD_W     = 33;
   localparam int REQ_DATA_W = ((ELEM_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((PROD_W + 7) / 8) * 8;

   // Index widths into the stores and the loop counters.
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int LP_W   = $clog2(2 * CELLS);

   // Result queue between the accumulator and the output port.
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Controller states.
   typedef enum logic [1:0] {
      ST_LOAD = 2'b01,
      ST_CALC = 2'b10
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              wr_en;
      logic              wr_left;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_left_addr;
      logic [ADDR_W-1:0] rd_right_addr;
      logic              first_term;
      logic              last_term;
      logic              last_elem;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_fire;
   } stat_type;

endpackage

// ===== src/mm3_ram.sv =====
module mm3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 9
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mm3_ctrl.sv =====
module mm3_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   output logic              load_ready,
   input  mm3_pkg::stat_type stat,
   output mm3_pkg::cmd_type  cmd
);

   mm3_pkg::state_type state_ff, state_in;

   logic [mm3_pkg::LP_W-1:0]    load_pos_ff, load_pos_in;
   logic [mm3_pkg::IDX_W-1:0]   row_ff, row_in;
   logic [mm3_pkg::IDX_W-1:0]   col_ff, col_in;
   logic [mm3_pkg::IDX_W-1:0]   k_ff, k_in;
   logic [mm3_pkg::Q_CNT_W-1:0] pend_ff, pend_in;

   logic issue;
   logic k_last;
   logic col_last;
   logic row_last;
   logic load_left;

   assign load_ready = (state_ff == mm3_pkg::ST_LOAD);

   assign k_last   = (k_ff == mm3_pkg::IDX_W'(mm3_pkg::DIM - 1));
   assign col_last = (col_ff == mm3_pkg::IDX_W'(mm3_pkg::DIM - 1));
   assign row_last = (row_ff == mm3_pkg::IDX_W'(mm3_pkg::DIM - 1));

   // A new element starts only while the result queue has room for it.
   assign issue = (state_ff == mm3_pkg::ST_CALC) &&
                  ((k_ff != '0) || (pend_ff < mm3_pkg::Q_CNT_W'(mm3_pkg::Q_DEPTH)));

   assign load_left = (load_pos_ff < mm3_pkg::LP_W'(mm3_pkg::CELLS));

   // Commands to the datapath.
   always_comb begin
      cmd.wr_en   = req_fire;
      cmd.wr_left = load_left;
      if (load_left) begin
         cmd.wr_addr = mm3_pkg::ADDR_W'(load_pos_ff);
      end else begin
         cmd.wr_addr = mm3_pkg::ADDR_W'(load_pos_ff - mm3_pkg::LP_W'(mm3_pkg::CELLS));
      end
      cmd.rd_en         = issue;
      cmd.rd_left_addr  = mm3_pkg::ADDR_W'(row_ff) * mm3_pkg::ADDR_W'(mm3_pkg::DIM) +
                          mm3_pkg::ADDR_W'(k_ff);
      cmd.rd_right_addr = mm3_pkg::ADDR_W'(k_ff) * mm3_pkg::ADDR_W'(mm3_pkg::DIM) +
                          mm3_pkg::ADDR_W'(col_ff);
      cmd.first_term    = (k_ff == '0);
      cmd.last_term     = k_last;
      cmd.last_elem     = k_last && col_last && row_last;
   end

   // Load counter, loop counters and state.
   always_comb begin
      state_in    = state_ff;
      load_pos_in = load_pos_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      k_in        = k_ff;
      case (state_ff)
         mm3_pkg::ST_LOAD: begin
            if (req_fire) begin
               if (load_pos_ff == mm3_pkg::LP_W'(2 * mm3_pkg::CELLS - 1)) begin
                  load_pos_in = '0;
                  row_in      = '0;
                  col_in      = '0;
                  k_in        = '0;
                  state_in    = mm3_pkg::ST_CALC;
               end else begin
                  load_pos_in = load_pos_ff + 1'b1;
               end
            end
         end
         mm3_pkg::ST_CALC: begin
            if (issue) begin
               if (!k_last) begin
                  k_in = k_ff + 1'b1;
               end else begin
                  k_in = '0;
                  if (!col_last) begin
                     col_in = col_ff + 1'b1;
                  end else begin
                     col_in = '0;
                     if (!row_last) begin
                        row_in = row_ff + 1'b1;
                     end else begin
                        row_in   = '0;
                        state_in = mm3_pkg::ST_LOAD;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = mm3_pkg::ST_LOAD;
         end
      endcase
   end

   // Elements started but not yet transferred out.
   always_comb begin
      pend_in = pend_ff;
      if (issue && (k_ff == '0) && !stat.out_fire) begin
         pend_in = pend_ff + 1'b1;
      end else if (!(issue && (k_ff == '0)) && stat.out_fire) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mm3_pkg::ST_LOAD;
         load_pos_ff <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         k_ff        <= '0;
         pend_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         load_pos_ff <= load_pos_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         k_ff        <= k_in;
         pend_ff     <= pend_in;
      end
   end

endmodule

// ===== src/mm3_datapath.sv =====
module mm3_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  mm3_pkg::cmd_type                 cmd,
   output mm3_pkg::stat_type                stat,
   input  logic [mm3_pkg::ELEM_W-1:0]       elem,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [mm3_pkg::PROD_W-1:0]       out_value,
   output logic                             out_last
);

   logic [mm3_pkg::ELEM_W-1:0] left_rd;
   logic [mm3_pkg::ELEM_W-1:0] right_rd;

   // Stage tags: read data valid, then product valid.
   logic v1_ff, v1_in;
   logic first1_ff, last1_ff, lastel1_ff;
   logic v2_ff, v2_in;
   logic first2_ff, last2_ff, lastel2_ff;

   logic signed [mm3_pkg::MUL_W-1:0]  prod_ff, prod_in;
   logic signed [mm3_pkg::PROD_W-1:0] prod_ext;
   logic [mm3_pkg::PROD_W-1:0]        acc_ff, acc_in;
   logic                              push;

   // Result queue.
   logic [mm3_pkg::PROD_W-1:0]  q_data_ff [mm3_pkg::Q_DEPTH];
   logic                        q_last_ff [mm3_pkg::Q_DEPTH];
   logic [mm3_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mm3_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mm3_pkg::Q_CNT_W-1:0] q_cnt_ff, q_cnt_in;
   logic                        pop;

   // Element stores for the left and right matrices.
   mm3_ram #(
      .WIDTH (mm3_pkg::ELEM_W),
      .DEPTH (mm3_pkg::CELLS)
   ) u_left_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en && cmd.wr_left),
      .wr_addr (cmd.wr_addr),
      .wr_data (elem),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_left_addr),
      .rd_data (left_rd)
   );

   mm3_ram #(
      .WIDTH (mm3_pkg::ELEM_W),
      .DEPTH (mm3_pkg::CELLS)
   ) u_right_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en && !cmd.wr_left),
      .wr_addr (cmd.wr_addr),
      .wr_data (elem),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_right_addr),
      .rd_data (right_rd)
   );

   // Multiply stage.
   assign v1_in   = cmd.rd_en;
   assign v2_in   = v1_ff;
   assign prod_in = $signed(left_rd) * $signed(right_rd);

   // Accumulate stage; the final term goes straight into the queue.
   assign prod_ext = mm3_pkg::PROD_W'(prod_ff);
   always_comb begin
      if (first2_ff) begin
         acc_in = prod_ext;
      end else begin
         acc_in = acc_ff + prod_ext;
      end
   end
   assign push = v2_ff && last2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      first1_ff  <= cmd.first_term;
      last1_ff   <= cmd.last_term;
      lastel1_ff <= cmd.last_elem;
      first2_ff  <= first1_ff;
      last2_ff   <= last1_ff;
      lastel2_ff <= lastel1_ff;
      if (v1_ff) begin
         prod_ff <= prod_in;
      end
      if (v2_ff) begin
         acc_ff <= acc_in;
      end
   end

   // Queue pointers and fill count.
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      q_cnt_in  = q_cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         q_cnt_in = q_cnt_ff + 1'b1;
      end else if (!push && pop) begin
         q_cnt_in = q_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         q_cnt_ff  <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_data_ff[wr_ptr_ff] <= acc_in;
         q_last_ff[wr_ptr_ff] <= lastel2_ff;
      end
   end

   assign out_valid     = (q_cnt_ff != '0);
   assign out_value     = q_data_ff[rd_ptr_ff];
   assign out_last      = q_last_ff[rd_ptr_ff];
   assign stat.out_fire = pop;

endmodule

// ===== src/matrix_multiply_3x3.sv =====
// Channel  Direction  Signals                           Contents
// req      in         req_tvalid/tready/tdata[15:0]     one element, A then B, row-major
// rsp      out        rsp_tvalid/tready/tdata[39:0]     one product element, row-major
//                     rsp_tlast                         marks the last product element
//
// Loading accepts one element per cycle; the 18th element starts the product.
// Each product element accumulates DIM terms on the shared multiply-accumulate unit.
// Input is refused while the product is being computed; loading of the next
// pair resumes as soon as the last store read is issued.
// A four-entry result queue lets the output stall; a new element waits while
// four elements are started but not yet transferred out.
// Reset is synchronous and clears control state only; the stores are not cleared.
module matrix_multiply_3x3 (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mm3_pkg::REQ_DATA_W-1:0]    req_tdata,  // [15:0] element_value
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mm3_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [32:0] product_value, rest zero
   output logic                              rsp_tlast
);

   mm3_pkg::cmd_type  cmd;
   mm3_pkg::stat_type stat;

   logic                       req_fire;
   logic [mm3_pkg::PROD_W-1:0] out_value;

   // An input transfer completes when both sides agree.
   assign req_fire = req_tvalid && req_tready;

   mm3_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .load_ready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mm3_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .elem      (req_tdata[mm3_pkg::ELEM_W-1:0]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (out_value),
      .out_last  (rsp_tlast)
   );

   // Pad the product to whole bytes.
   assign rsp_tdata = mm3_pkg::RSP_DATA_W'(out_value);

endmodule

// ===== src/mm3_checker.sv =====
module mm3_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mm3_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);

   logic [mm3_pkg::LP_W-1:0]   in_cnt_ff, in_cnt_in;
   logic [mm3_pkg::ADDR_W-1:0] out_cnt_ff, out_cnt_in;
   logic [1:0]                 pend_ff, pend_in;
   logic                       req_fire;
   logic                       rsp_fire;
   logic                       pair_done;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;
   assign pair_done = req_fire && (in_cnt_ff == mm3_pkg::LP_W'(2 * mm3_pkg::CELLS - 1));

   // Track input position, output position and pairs awaiting their product.
   always_comb begin
      in_cnt_in  = in_cnt_ff;
      out_cnt_in = out_cnt_ff;
      pend_in    = pend_ff;
      if (req_fire) begin
         in_cnt_in = pair_done ? '0 : in_cnt_ff + 1'b1;
      end
      if (rsp_fire) begin
         out_cnt_in = rsp_tlast ? '0 : out_cnt_ff + 1'b1;
      end
      if (pair_done && !(rsp_fire && rsp_tlast)) begin
         pend_in = pend_ff + 1'b1;
      end else if (!pair_done && rsp_fire && rsp_tlast) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cnt_ff  <= '0;
         out_cnt_ff <= '0;
         pend_ff    <= '0;
      end else begin
         in_cnt_ff  <= in_cnt_in;
         out_cnt_ff <= out_cnt_in;
         pend_ff    <= pend_in;
      end
   end

   // A stalled result holds its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Padding bits above the product stay zero.
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[mm3_pkg::RSP_DATA_W-1:mm3_pkg::PROD_W] == '0))
      else $error("nonzero padding in result data");

   // The last flag falls exactly on the final element of each product.
   a_rsp_last: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> (rsp_tlast == (out_cnt_ff == mm3_pkg::ADDR_W'(mm3_pkg::CELLS - 1))))
      else $error("last flag out of place");

   // No result appears without a fully loaded matrix pair behind it.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pend_ff != '0))
      else $error("result without a loaded matrix pair");

endmodule

bind matrix_multiply_3x3 mm3_checker u_mm3_checker (.*);
